>>> rtl/core/binhex_char_stream_decoder_unit_assert.svh
`ifndef BINHEX_CHAR_STREAM_DECODER_UNIT_ASSERT_SVH
`define BINHEX_CHAR_STREAM_DECODER_UNIT_ASSERT_SVH

// checked only while out of reset
`ifndef SYNTHESIS
`define BHX_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define BHX_ASSERT(label, clk, rst_n, prop, msg)
`endif

// checked at every edge, reset included
`ifndef SYNTHESIS
`define BHX_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BHX_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> rtl/core/bhx_pkg.sv
`default_nettype none

package bhx_pkg;

    localparam logic [1:0] ST_BYTES     = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR  = 2'd1;
    localparam logic [1:0] ST_ESC_FIRST = 2'd2;
    localparam logic [1:0] ST_END       = 2'd3;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] RLE_ESC  = 8'h90;

    localparam int CodeCount = 64;

    localparam logic [CodeCount*8-1:0] CODE_CHARS =
        "!\"#$%&'()*+,-012345689@ABCDEFGHIJKLMNPQRSTUVXYZ[`abcdefhijklmpqr";

    typedef struct packed {
        logic       hit;
        logic [5:0] value;
    } t_code;

    function automatic t_code code_of(input logic [7:0] ch);
        t_code res;
        res.hit   = 1'b0;
        res.value = 6'd0;
        for (int k = 0; k < CodeCount; k++) begin
            if (CODE_CHARS[(CodeCount-1-k)*8 +: 8] == ch) begin
                res.hit   = 1'b1;
                res.value = 6'(k);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bhx_ifs.sv
`default_nettype none

interface bhx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface bhx_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] out_byte;
    logic [7:0] count;

    modport source (output valid, output status, output out_byte, output count, input ready);
    modport sink   (input valid, input status, input out_byte, input count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/binhex_char_stream_decoder_unit.sv
// channel   dir  word                           handshake
// i_in      in   ch[7:0]                        valid/ready
// o_out     out  status[1:0] out_byte count     valid/ready
//
// An accepted character goes from the input register through the single decode
// pass to the result register; one character per cycle while o_out does not stall.
// A character that yields no result leaves no word on o_out.
// Reset (i_rst_n low, synchronous) returns to waiting for the opening colon.
// A stalled o_out holds one word in the result register and one character in the
// input register; i_in.ready drops only when both are full.
`default_nettype none
`include "binhex_char_stream_decoder_unit_assert.svh"

module binhex_char_stream_decoder_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bhx_in_if.sink     i_in,
    bhx_out_if.source  o_out
);

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_STOP = 2'd2;

    logic       r_in_valid;
    logic [7:0] r_ch;

    logic [1:0] r_phase,   n_phase;
    logic [1:0] r_held,    n_held;
    logic [7:0] r_partial, n_partial;
    logic       r_esc,     n_esc;
    logic [7:0] r_prev,    n_prev;
    logic       r_seen,    n_seen;
    logic       r_skip,    n_skip;

    logic       r_out_valid;
    logic [1:0] r_status;
    logic [7:0] r_byte;
    logic [7:0] r_count;

    logic          adv;
    logic          res_valid;
    logic [1:0]    res_status;
    logic [7:0]    res_byte;
    logic [7:0]    res_count;
    logic          done;
    logic [7:0]    dec_byte;
    bhx_pkg::t_code code;

    assign adv         = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_in_valid || adv;

    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_status;
    assign o_out.out_byte = r_byte;
    assign o_out.count    = r_count;

    assign code = bhx_pkg::code_of(r_ch);

    always_comb begin
        n_phase    = r_phase;
        n_held     = r_held;
        n_partial  = r_partial;
        n_esc      = r_esc;
        n_prev     = r_prev;
        n_seen     = r_seen;
        n_skip     = r_skip;
        res_valid  = 1'b0;
        res_status = bhx_pkg::ST_BYTES;
        res_byte   = 8'd0;
        res_count  = 8'd0;
        done       = 1'b0;
        dec_byte   = 8'd0;
        case (r_phase)
            PH_WAIT: begin
                if (r_ch == bhx_pkg::CH_COLON) begin
                    n_phase = PH_RUN;
                end
            end
            PH_RUN: begin
                if (r_skip) begin
                    if (r_ch == bhx_pkg::CH_CR || r_ch == bhx_pkg::CH_LF) begin
                        n_skip = 1'b0;
                    end
                end else if (r_ch == 8'd0 || r_ch[7]) begin
                    n_skip = 1'b1;
                end else if (r_ch == bhx_pkg::CH_COLON) begin
                    n_phase    = PH_STOP;
                    res_valid  = 1'b1;
                    res_status = bhx_pkg::ST_END;
                end else if (r_ch == bhx_pkg::CH_SPACE || r_ch == bhx_pkg::CH_CR
                             || r_ch == bhx_pkg::CH_LF) begin
                    n_held = r_held;
                end else if (!code.hit) begin
                    res_valid  = 1'b1;
                    res_status = bhx_pkg::ST_BAD_CHAR;
                    res_byte   = r_ch;
                end else begin
                    case (r_held)
                        2'd0: begin
                            n_partial = {code.value, 2'b00};
                            n_held    = 2'd1;
                        end
                        2'd1: begin
                            dec_byte  = r_partial | {6'd0, code.value[5:4]};
                            n_partial = {code.value[3:0], 4'd0};
                            n_held    = 2'd2;
                            done      = 1'b1;
                        end
                        2'd2: begin
                            dec_byte  = r_partial | {4'd0, code.value[5:2]};
                            n_partial = {code.value[1:0], 6'd0};
                            n_held    = 2'd3;
                            done      = 1'b1;
                        end
                        default: begin
                            dec_byte  = r_partial | {2'd0, code.value};
                            n_partial = 8'd0;
                            n_held    = 2'd0;
                            done      = 1'b1;
                        end
                    endcase
                    if (done) begin
                        if (r_esc) begin
                            n_esc = 1'b0;
                            if (dec_byte == 8'd0) begin
                                n_prev    = bhx_pkg::RLE_ESC;
                                res_valid = 1'b1;
                                res_byte  = bhx_pkg::RLE_ESC;
                                res_count = 8'd1;
                            end else if (dec_byte != 8'd1) begin
                                res_valid = 1'b1;
                                res_byte  = r_prev;
                                res_count = dec_byte - 8'd1;
                            end
                        end else if (dec_byte == bhx_pkg::RLE_ESC) begin
                            if (!r_seen) begin
                                n_phase    = PH_STOP;
                                res_valid  = 1'b1;
                                res_status = bhx_pkg::ST_ESC_FIRST;
                            end else begin
                                n_esc = 1'b1;
                            end
                        end else begin
                            n_seen    = 1'b1;
                            n_prev    = dec_byte;
                            res_valid = 1'b1;
                            res_byte  = dec_byte;
                            res_count = 8'd1;
                        end
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_WAIT;
            r_held      <= 2'd0;
            r_partial   <= 8'd0;
            r_esc       <= 1'b0;
            r_prev      <= 8'd0;
            r_seen      <= 1'b0;
            r_skip      <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid && res_valid;
            end
            if (r_in_valid && adv) begin
                r_phase   <= n_phase;
                r_held    <= n_held;
                r_partial <= n_partial;
                r_esc     <= n_esc;
                r_prev    <= n_prev;
                r_seen    <= n_seen;
                r_skip    <= n_skip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_ch <= i_in.ch;
        end
        if (adv && r_in_valid && res_valid) begin
            r_status <= res_status;
            r_byte   <= res_byte;
            r_count  <= res_count;
        end
    end

    `BHX_ASSERT(a_bytes_count_nonzero, i_clk, i_rst_n, (r_out_valid && r_status == bhx_pkg::ST_BYTES) |-> (r_count != 8'd0), "byte word with zero count")
    `BHX_ASSERT(a_stopped_silent, i_clk, i_rst_n, (r_phase[1] && r_in_valid && adv) |=> !r_out_valid, "word produced after stop")
    `BHX_ASSERT(a_esc_after_first, i_clk, i_rst_n, r_esc |-> r_seen, "escape pending before first byte")
    `BHX_ASSERT(a_group_start_clear, i_clk, i_rst_n, (r_held == 2'd0) |-> (r_partial == 8'd0), "partial bits held at group start")
    `BHX_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> (r_phase == PH_WAIT && !r_out_valid && !r_in_valid), "reset did not clear control")

endmodule

`default_nettype wire
